// ===== rtl/pid_pkg.sv =====
// package for the pairwise identity distance block
// types, widths and residue symbol constants shared by all rtl files
package pid_pkg;

  localparam int unsigned CNT_W       = 17;
  localparam int unsigned RES_W       = 8;
  localparam logic [CNT_W-1:0] MAX_COLUMNS = 17'd65536;

  localparam logic [RES_W-1:0] GAP_SYM       = 8'h2D;  // '-'
  localparam logic [RES_W-1:0] INDET_PROTEIN = 8'h58;  // 'X'
  localparam logic [RES_W-1:0] INDET_NUC     = 8'h4E;  // 'N'

  // one quotient bit per step: integer bit plus 16 fraction bits
  localparam int unsigned DIV_STEPS = CNT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int unsigned REM_W     = CNT_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0] match_total;
    logic [CNT_W-1:0] valid_total;
  } pair_totals_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < MAX_COLUMNS) ? v + CNT_W'(1) : MAX_COLUMNS;
  endfunction

endpackage

// ===== rtl/pid_front.sv =====
// front end: accepts residue columns, classifies them and accumulates counts
// pushes the pair totals into the queue on the last column; uses pid_pkg
module pid_front import pid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               protein_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RES_W-1:0]   residue_a_i,
  input  logic [RES_W-1:0]   residue_b_i,
  input  logic               last_column_i,
  input  logic               full_i,
  output logic               push_o,
  output pair_totals_t       push_data_o
);

  logic [CNT_W-1:0] match_q, match_d;
  logic [CNT_W-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] match_nxt, valid_nxt;
  logic [RES_W-1:0] indet;
  logic             va, vb, fire;

  assign in_ready_o = ~full_i;
  assign fire       = in_valid_i & in_ready_o;

  assign indet = protein_mode_i ? INDET_PROTEIN : INDET_NUC;
  assign va    = (residue_a_i != GAP_SYM) && (residue_a_i != indet);
  assign vb    = (residue_b_i != GAP_SYM) && (residue_b_i != indet);

  always_comb begin
    valid_nxt = (va | vb) ? sat_inc(valid_q) : valid_q;
    match_nxt = (va & vb & (residue_a_i == residue_b_i)) ? sat_inc(match_q) : match_q;
    match_d   = match_q;
    valid_d   = valid_q;
    if (fire) begin
      // counters clear once the pair is handed over
      match_d = last_column_i ? '0 : match_nxt;
      valid_d = last_column_i ? '0 : valid_nxt;
    end
  end

  assign push_o                  = fire & last_column_i;
  assign push_data_o.match_total = match_nxt;
  assign push_data_o.valid_total = valid_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      valid_q <= '0;
    end else begin
      match_q <= match_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/pid_queue.sv =====
// short queue of pair totals between front and back ends
// lets the column stream continue while a division is running; uses pid_pkg
module pid_queue import pid_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pair_totals_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output pair_totals_t pop_data_o
);

  pair_totals_t      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/pid_back.sv =====
// back end: bit-serial restoring division for the q16 distance
// pops pair totals from the queue and holds the result in an output register; uses pid_pkg
module pid_back import pid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  pair_totals_t     pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CNT_W-1:0] match_total_o,
  output logic [CNT_W-1:0] valid_total_o,
  output logic [CNT_W-1:0] distance_q16_o,
  output logic             empty_pair_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     match_q, match_d;
  logic [CNT_W-1:0]     valid_q, valid_d;
  logic                 empty_q, empty_d;
  logic [REM_W-1:0]     divisor, rem_sub;
  logic                 ge;

  assign divisor = {1'b0, valid_q};
  assign ge      = (rem_q >= divisor);
  assign rem_sub = ge ? rem_q - divisor : rem_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    match_d = match_q;
    valid_d = valid_q;
    empty_d = empty_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          match_d = pop_data_i.match_total;
          valid_d = pop_data_i.valid_total;
          // match never exceeds valid, so the miss count fits
          rem_d   = {1'b0, pop_data_i.valid_total - pop_data_i.match_total};
          quo_d   = '0;
          step_d  = DIV_CNT_W'(DIV_STEPS);
          empty_d = (pop_data_i.valid_total == '0);
          state_d = (pop_data_i.valid_total == '0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d  = {quo_q[CNT_W-2:0], ge};
        rem_d  = {rem_sub[REM_W-2:0], 1'b0};
        step_d = step_q - DIV_CNT_W'(1);
        if (step_q == DIV_CNT_W'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = (state_q == ST_OUT);
  assign match_total_o  = match_q;
  assign valid_total_o  = valid_q;
  assign distance_q16_o = quo_q;
  assign empty_pair_o   = empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    match_q <= match_d;
    valid_q <= valid_d;
    empty_q <= empty_d;
  end

endmodule

// ===== rtl/pairwise_identity_distance.sv =====
// top level of the pairwise identity distance block
// ties front end, totals queue and divider back end together; uses pid_pkg
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------------
//   cfg       cfg_valid_i / cfg_ready_o cfg_data_i (protein_mode)
//   in        in_valid_i / in_ready_o   residue_a_i, residue_b_i, last_column_i
//   out       out_valid_o / out_ready_i match_total_o, valid_total_o,
//                                       distance_q16_o, empty_pair_o
//
// columns are taken one per cycle while the two-entry totals queue has room.
// each pair is then popped and run through the bit-serial divider (one quotient
// bit a cycle) before its result is shown; an empty pair skips the divider.
// input stalls only when the queue is full; output stalls hold the result register.
// reset is asynchronous, active low; protein_mode comes up as 1, counters as 0.
module pairwise_identity_distance import pid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RES_W-1:0] residue_a_i,
  input  logic [RES_W-1:0] residue_b_i,
  input  logic             last_column_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CNT_W-1:0] match_total_o,
  output logic [CNT_W-1:0] valid_total_o,
  output logic [CNT_W-1:0] distance_q16_o,
  output logic             empty_pair_o
);

  logic         protein_mode_q;
  logic         push, full, pop, empty;
  pair_totals_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protein_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      protein_mode_q <= cfg_data_i;
    end
  end

  pid_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .protein_mode_i (protein_mode_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .residue_a_i    (residue_a_i),
    .residue_b_i    (residue_b_i),
    .last_column_i  (last_column_i),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  pid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  pid_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_total_o  (match_total_o),
    .valid_total_o  (valid_total_o),
    .distance_q16_o (distance_q16_o),
    .empty_pair_o   (empty_pair_o)
  );

endmodule
